// ===== design/sbt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared sizes, command and status codes, and table entry layouts for the
// service backend translator.
// ----------------------------------------------------------------------------
package sbt_pkg;

  // Table sizes
  localparam int SERVICE_ENTRIES = 16;
  localparam int MAX_SLOTS       = 16;
  localparam int BACKEND_ENTRIES = 256;

  localparam int SVC_W  = $clog2(SERVICE_ENTRIES);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int BK_W   = $clog2(BACKEND_ENTRIES);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int PROTO_W  = 8;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int RND_W    = 32;
  localparam int SIDX_W   = 4;
  localparam int SNUM_W   = 5;
  localparam int CNT_W    = 5;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;

  // Stream word widths
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 56;

  // Protocol numbers
  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CONNECT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_SVC    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_SLOT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WR_BACKEND = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_XLATED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SERVICE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BACKEND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SKIP_LOCAL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WRITE_DONE = 3'd4;

  // Table entry layouts
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
  } svc_entry_t;

  typedef struct packed {
    logic              vld;
    logic [ID_W-1:0]   id;
  } slot_entry_t;

  typedef struct packed {
    logic              vld;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
  } bk_entry_t;

endpackage
`default_nettype wire

// ===== design/service_backend_translator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// service_backend_translator
// Maps a connect to a virtual address/port onto a backend through service,
// slot and backend tables held in synchronous RAMs; write words load tables.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser
//  s_axis   in   protocol..local_socket_hit (112 bits)   cmd
//  m_axis   out  out_address, out_port, chosen_backend   status
//
//  Reset starts a clearing pass over the 256-entry slot and backend RAMs
//  with tready low; the 16 service valid bits are flops cleared at once.
//  Table writes: a word goes through S_WRITE and then waits in S_DONE.
//  A connect scans the service RAM one entry a cycle, runs a bit-serial
//  32-step remainder for TCP, then reads the slot and backend RAMs before
//  its result waits in S_DONE.
//  One word is in flight at a time; the next is taken while a result waits
//  in the output register, and its own result holds in S_DONE until then.
module service_backend_translator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // protocol, address, port, random_value, service_index, slot_number,
  // slot_total, backend_index, entry_valid, local_socket_hit
  input  wire logic [sbt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd
  input  wire logic [sbt_pkg::CMD_W-1:0]         s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // out_address, out_port, chosen_backend
  output      logic [sbt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status
  output      logic [sbt_pkg::STATUS_W-1:0]      m_axis_tuser
);
  import sbt_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_SCAN, S_DIV, S_SLOT, S_SLOTRD, S_BKRD, S_DONE
  } state_t;

  localparam logic [SVC_W-1:0] SVC_LAST = SVC_W'(SERVICE_ENTRIES - 1);

  localparam int SLOT_ENTRIES = SERVICE_ENTRIES * MAX_SLOTS;
  localparam int CLR_N = (SLOT_ENTRIES > BACKEND_ENTRIES) ? SLOT_ENTRIES : BACKEND_ENTRIES;
  localparam int CLR_W = $clog2(CLR_N);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);

  state_t state;

  // Latched request word
  logic [CMD_W-1:0]   req_cmd;
  logic [PROTO_W-1:0] req_proto;
  logic [ADDR_W-1:0]  req_addr;
  logic [PORT_W-1:0]  req_port;
  logic [SIDX_W-1:0]  req_sidx;
  logic [SNUM_W-1:0]  req_snum;
  logic [CNT_W-1:0]   req_stot;
  logic [ID_W-1:0]    req_bidx;
  logic               req_valid;
  logic               req_local;

  // Working registers
  logic [SVC_W-1:0]  scan_idx;
  logic [SVC_W-1:0]  pend_idx;
  logic              pend;
  logic [SVC_W-1:0]  svc_sel;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  rem;
  logic [RND_W-1:0]  dvd;
  logic [4:0]        bit_cnt;
  logic [CLR_W-1:0]  clr_idx;

  // Result staging
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic [PORT_W-1:0]   res_port;
  logic [ID_W-1:0]     res_id;

  // Service valid bits
  logic [SERVICE_ENTRIES-1:0] svc_valid;

  // Table RAMs
  svc_entry_t        svc_mem [SERVICE_ENTRIES];
  slot_entry_t       slot_mem [SLOT_ENTRIES];
  bk_entry_t         bk_mem [BACKEND_ENTRIES];
  svc_entry_t        svc_rdata;
  slot_entry_t       slot_rdata;
  bk_entry_t         bk_rdata;

  logic [SVC_W+SLOT_W-1:0] slot_pos;
  logic [SVC_W+SLOT_W-1:0] slot_wpos;
  logic [SNUM_W-1:0]       snum_m1;
  logic                    wr_svc, wr_slot, wr_bk;
  logic                    clr_slot, clr_bk;
  logic                    svc_hit;
  logic                    is_tcp, is_udp;
  logic                    out_load;
  logic [CNT_W:0]          div_t;
  logic [CNT_W-1:0]        rem_next;

  assign s_axis_tready = (state == S_IDLE);

  // Decode helpers
  assign is_tcp   = (req_proto == PROTO_TCP);
  assign is_udp   = (req_proto == PROTO_UDP);
  assign slot_pos = {svc_sel, rem[SLOT_W-1:0]};
  assign snum_m1  = req_snum - SNUM_W'(1);
  assign slot_wpos = {req_sidx[SVC_W-1:0], snum_m1[SLOT_W-1:0]};

  assign wr_svc  = (state == S_WRITE) && (req_cmd == CMD_WR_SVC) &&
                   ({1'b0, req_sidx} < (SIDX_W+1)'(SERVICE_ENTRIES));
  assign wr_slot = (state == S_WRITE) && (req_cmd == CMD_WR_SLOT) &&
                   ({1'b0, req_sidx} < (SIDX_W+1)'(SERVICE_ENTRIES)) &&
                   (req_snum != '0) && (req_snum <= SNUM_W'(MAX_SLOTS));
  assign wr_bk   = (state == S_WRITE) && (req_cmd == CMD_WR_BACKEND) &&
                   ({1'b0, req_bidx} < (ID_W+1)'(BACKEND_ENTRIES));

  // Clearing pass after reset
  assign clr_slot = (state == S_CLEAR) && ({1'b0, clr_idx} < (CLR_W+1)'(SLOT_ENTRIES));
  assign clr_bk   = (state == S_CLEAR) && ({1'b0, clr_idx} < (CLR_W+1)'(BACKEND_ENTRIES));

  // Result goes out once the output register is free
  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Service match on the entry read last cycle
  assign svc_hit = pend && svc_valid[pend_idx] &&
                   (svc_rdata.addr == req_addr) && (svc_rdata.port == req_port);

  // One restoring remainder step
  assign div_t    = {rem, dvd[RND_W-1]};
  assign rem_next = (div_t >= {1'b0, cnt}) ? CNT_W'(div_t - {1'b0, cnt})
                                           : div_t[CNT_W-1:0];

  // RAM reads, registered
  always_ff @(posedge clk) begin
    svc_rdata  <= svc_mem[scan_idx];
    slot_rdata <= slot_mem[slot_pos];
    bk_rdata   <= bk_mem[slot_rdata.id[BK_W-1:0]];
  end

  // RAM writes
  always_ff @(posedge clk) begin
    if (wr_svc) begin
      svc_mem[req_sidx[SVC_W-1:0]] <= '{cnt: req_stot, port: req_port, addr: req_addr};
    end
    if (clr_slot) begin
      slot_mem[(SVC_W+SLOT_W)'(clr_idx)] <= '0;
    end else if (wr_slot) begin
      slot_mem[slot_wpos] <= '{vld: req_valid, id: req_bidx};
    end
    if (clr_bk) begin
      bk_mem[BK_W'(clr_idx)] <= '0;
    end else if (wr_bk) begin
      bk_mem[req_bidx[BK_W-1:0]] <= '{vld: req_valid, port: req_port, addr: req_addr};
    end
  end

  // Control sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      m_axis_tvalid <= 1'b0;
      svc_valid     <= '0;
      pend          <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {res_id, res_port, res_addr};
        m_axis_tuser  <= res_status;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CLR_W'(1);
          if (clr_idx == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_cmd    <= s_axis_tuser;
            req_proto  <= s_axis_tdata[7:0];
            req_addr   <= s_axis_tdata[39:8];
            req_port   <= s_axis_tdata[55:40];
            dvd        <= s_axis_tdata[87:56];
            req_sidx   <= s_axis_tdata[91:88];
            req_snum   <= s_axis_tdata[96:92];
            req_stot   <= s_axis_tdata[101:97];
            req_bidx   <= s_axis_tdata[109:102];
            req_valid  <= s_axis_tdata[110];
            req_local  <= s_axis_tdata[111];
            res_addr   <= s_axis_tdata[39:8];
            res_port   <= s_axis_tdata[55:40];
            res_id     <= '0;
            scan_idx   <= '0;
            pend       <= 1'b0;
            state      <= (s_axis_tuser == CMD_CONNECT) ? S_SCAN : S_WRITE;
          end
        end
        S_WRITE: begin
          if (wr_svc) begin
            svc_valid[req_sidx[SVC_W-1:0]] <= req_valid;
          end
          res_status <= ST_WRITE_DONE;
          state      <= S_DONE;
        end
        S_SCAN: begin
          scan_idx <= scan_idx + SVC_W'(1);
          pend     <= 1'b1;
          pend_idx <= scan_idx;
          if (svc_hit) begin
            svc_sel <= pend_idx;
            cnt     <= svc_rdata.cnt;
            rem     <= '0;
            bit_cnt <= '0;
            if (svc_rdata.cnt == '0) begin
              res_status <= ST_NO_BACKEND;
              state      <= S_DONE;
            end else if (is_tcp) begin
              state <= S_DIV;
            end else begin
              state <= S_SLOT;
            end
          end else if (pend && (pend_idx == SVC_LAST)) begin
            res_status <= ST_NO_SERVICE;
            state      <= S_DONE;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          dvd     <= {dvd[RND_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'd31) begin
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          // slot number rem+1 past the table means a missing slot
          if (rem >= CNT_W'(MAX_SLOTS)) begin
            res_status <= ST_NO_BACKEND;
            state      <= S_DONE;
          end else begin
            state <= S_SLOTRD;
          end
        end
        S_SLOTRD: begin
          if (!slot_rdata.vld) begin
            res_status <= ST_NO_BACKEND;
            state      <= S_DONE;
          end else begin
            res_id <= slot_rdata.id;
            state  <= S_BKRD;
          end
        end
        S_BKRD: begin
          if (!bk_rdata.vld || ({1'b0, res_id} >= (ID_W+1)'(BACKEND_ENTRIES))) begin
            res_status <= ST_NO_BACKEND;
          end else if (req_local && (is_tcp || is_udp)) begin
            res_status <= ST_SKIP_LOCAL;
          end else begin
            res_status <= ST_XLATED;
            res_addr   <= bk_rdata.addr;
            res_port   <= bk_rdata.port;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_write_no_id: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_WRITE_DONE)) |-> (m_axis_tdata[55:48] == '0))
    else $error("write result carries a backend id");

  a_nosvc_no_id: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_NO_SERVICE)) |-> (m_axis_tdata[55:48] == '0))
    else $error("no-service result carries a backend id");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ((cnt != '0) && (rem < cnt)))
    else $error("remainder out of range during division");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken while one is in flight");

endmodule
`default_nettype wire

// ===== test/service_backend_translator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// service_backend_translator_tb
// Self-checking bench for the service backend translator. Loads the service,
// slot and backend tables through write words, sends connect words and checks
// every result word against a local copy of the tables, with random gaps and
// back-pressure on both streams.
// ----------------------------------------------------------------------------
module service_backend_translator_tb;
  import sbt_pkg::*;

  // One input word, split into its fields
  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [RND_W-1:0]   rnd;
    logic [SIDX_W-1:0]  sidx;
    logic [SNUM_W-1:0]  snum;
    logic [CNT_W-1:0]   stot;
    logic [ID_W-1:0]    bidx;
    logic               ena;
    logic               local_hit;
  } xlate_req_t;

  // One result word
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [ID_W-1:0]     id;
  } xlate_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = CMD_CONNECT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // Local copy of the translation tables
  logic              svc_on   [SERVICE_ENTRIES];
  logic [ADDR_W-1:0] svc_addr [SERVICE_ENTRIES];
  logic [PORT_W-1:0] svc_port [SERVICE_ENTRIES];
  logic [CNT_W-1:0]  svc_cnt  [SERVICE_ENTRIES];
  logic              slot_on  [SERVICE_ENTRIES*MAX_SLOTS];
  logic [ID_W-1:0]   slot_id  [SERVICE_ENTRIES*MAX_SLOTS];
  logic              bk_on    [BACKEND_ENTRIES];
  logic [ADDR_W-1:0] bk_addr  [BACKEND_ENTRIES];
  logic [PORT_W-1:0] bk_port  [BACKEND_ENTRIES];

  xlate_res_t  pending_results [$];
  int unsigned errors  = 0;
  bit          no_gaps = 1'b0;

  service_backend_translator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Table copy after reset: every entry invalid
  function automatic void clear_tables();
    for (int i = 0; i < SERVICE_ENTRIES; i++) svc_on[i] = 1'b0;
    for (int i = 0; i < SERVICE_ENTRIES*MAX_SLOTS; i++) slot_on[i] = 1'b0;
    for (int i = 0; i < BACKEND_ENTRIES; i++) bk_on[i] = 1'b0;
  endfunction

  // Applies one word to the table copy and returns the result it must give
  function automatic xlate_res_t translate(input xlate_req_t r);
    xlate_res_t  res;
    logic        found;
    int unsigned s, slot, pos, cnt, rnd;
    res.status = ST_WRITE_DONE;
    res.addr   = r.addr;
    res.port   = r.port;
    res.id     = '0;
    found      = 1'b0;
    s          = 0;
    case (r.cmd)
      CMD_WR_SVC: begin
        svc_on[r.sidx]   = r.ena;
        svc_addr[r.sidx] = r.addr;
        svc_port[r.sidx] = r.port;
        svc_cnt[r.sidx]  = r.stot;
      end
      CMD_WR_SLOT: begin
        // slot numbers outside 1..MAX_SLOTS leave the table alone
        if (r.snum >= 1 && r.snum <= MAX_SLOTS) begin
          pos          = r.sidx * MAX_SLOTS + r.snum - 1;
          slot_on[pos] = r.ena;
          slot_id[pos] = r.bidx;
        end
      end
      CMD_WR_BACKEND: begin
        bk_on[r.bidx]   = r.ena;
        bk_addr[r.bidx] = r.addr;
        bk_port[r.bidx] = r.port;
      end
      default: begin
        // lowest matching service wins
        for (int i = 0; i < SERVICE_ENTRIES; i++) begin
          if (!found && svc_on[i] && svc_addr[i] == r.addr && svc_port[i] == r.port) begin
            found = 1'b1;
            s     = i;
          end
        end
        if (!found) begin
          res.status = ST_NO_SERVICE;
        end else if (svc_cnt[s] == 0) begin
          res.status = ST_NO_BACKEND;
        end else begin
          cnt  = 32'(svc_cnt[s]);
          rnd  = r.rnd;
          slot = (r.proto == PROTO_TCP) ? (rnd % cnt) + 1 : 1;
          pos  = s * MAX_SLOTS + slot - 1;
          if (slot > MAX_SLOTS || !slot_on[pos]) begin
            res.status = ST_NO_BACKEND;
          end else begin
            res.id = slot_id[pos];
            if (!bk_on[res.id]) begin
              res.status = ST_NO_BACKEND;
            end else if (r.local_hit && (r.proto == PROTO_TCP || r.proto == PROTO_UDP)) begin
              res.status = ST_SKIP_LOCAL;
            end else begin
              res.status = ST_XLATED;
              res.addr   = bk_addr[res.id];
              res.port   = bk_port[res.id];
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // Sends one word, with a random lead-in gap, and records its result
  task automatic send_word(input xlate_req_t r);
    while (!no_gaps && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.local_hit, r.ena, r.bidx, r.stot, r.snum, r.sidx,
                      r.rnd, r.port, r.addr, r.proto};
    s_axis_tuser  <= r.cmd;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(translate(r));
  endtask

  // Holds the input stream until every result has come back
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic connect(input logic [PROTO_W-1:0] proto, input logic [ADDR_W-1:0] addr,
                         input logic [PORT_W-1:0] port, input logic [RND_W-1:0] rnd,
                         input logic local_hit);
    xlate_req_t r = '{default: '0};
    r.cmd       = CMD_CONNECT;
    r.proto     = proto;
    r.addr      = addr;
    r.port      = port;
    r.rnd       = rnd;
    r.local_hit = local_hit;
    send_word(r);
  endtask

  task automatic wr_service(input logic [SIDX_W-1:0] sidx, input logic [ADDR_W-1:0] addr,
                            input logic [PORT_W-1:0] port, input logic [CNT_W-1:0] cnt,
                            input logic ena);
    xlate_req_t r = '{default: '0};
    r.cmd  = CMD_WR_SVC;
    r.sidx = sidx;
    r.addr = addr;
    r.port = port;
    r.stot = cnt;
    r.ena  = ena;
    send_word(r);
  endtask

  task automatic wr_slot(input logic [SIDX_W-1:0] sidx, input logic [SNUM_W-1:0] snum,
                         input logic [ID_W-1:0] id, input logic ena);
    xlate_req_t r = '{default: '0};
    r.cmd  = CMD_WR_SLOT;
    r.sidx = sidx;
    r.snum = snum;
    r.bidx = id;
    r.ena  = ena;
    send_word(r);
  endtask

  task automatic wr_backend(input logic [ID_W-1:0] id, input logic [ADDR_W-1:0] addr,
                            input logic [PORT_W-1:0] port, input logic ena);
    xlate_req_t r = '{default: '0};
    r.cmd  = CMD_WR_BACKEND;
    r.bidx = id;
    r.addr = addr;
    r.port = port;
    r.ena  = ena;
    send_word(r);
  endtask

  // Nothing installed yet: every connect misses
  task automatic test_empty_tables();
    connect(PROTO_TCP, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b1);
    connect(8'hff, 32'h0, 16'h0, 32'h0, 1'b0);
    wr_backend(8'hff, 32'h0, 16'h0, 1'b0);
  endtask

  // Plain translation, slot choice by protocol, local socket skip
  task automatic test_translation();
    wr_backend(8'hff, 32'hffff_ffff, 16'hffff, 1'b1);
    wr_backend(8'h00, 32'h0a00_0001, 16'd8080, 1'b1);
    wr_service(4'd15, 32'hffff_ffff, 16'hffff, 5'd16, 1'b1);
    wr_slot(4'd15, 5'd16, 8'hff, 1'b1);
    wr_slot(4'd15, 5'd1, 8'h00, 1'b1);
    // TCP with all-ones random lands on the last slot
    connect(PROTO_TCP, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b0);
    connect(PROTO_UDP, 32'hffff_ffff, 16'hffff, 32'h0, 1'b0);
    // local socket is ignored for protocols other than TCP and UDP
    connect(8'hff, 32'hffff_ffff, 16'hffff, 32'h0, 1'b1);
    connect(PROTO_UDP, 32'hffff_ffff, 16'hffff, 32'h0, 1'b1);
    connect(PROTO_TCP, 32'hffff_ffff, 16'hffff, 32'h0, 1'b1);
  endtask

  // Duplicate services, empty and oversized slot counts, missing entries
  task automatic test_special_cases();
    wr_service(4'd3, 32'hc0a8_0001, 16'd443, 5'd0, 1'b1);
    wr_service(4'd9, 32'hc0a8_0001, 16'd443, 5'd2, 1'b1);
    connect(PROTO_TCP, 32'hc0a8_0001, 16'd443, 32'd1, 1'b0);
    // count 31: random 20 picks slot 21, past the slot table
    wr_service(4'd3, 32'hc0a8_0001, 16'd443, 5'd31, 1'b1);
    connect(PROTO_TCP, 32'hc0a8_0001, 16'd443, 32'd20, 1'b0);
    connect(PROTO_TCP, 32'hc0a8_0001, 16'd443, 32'd4, 1'b0);
    // slot points at a backend that was never installed
    wr_slot(4'd3, 5'd1, 8'd77, 1'b1);
    connect(PROTO_UDP, 32'hc0a8_0001, 16'd443, 32'h0, 1'b0);
    wr_slot(4'd3, 5'd0, 8'd1, 1'b1);
    wr_slot(4'd3, 5'd31, 8'd1, 1'b1);
    // removed backend behind a valid slot
    wr_backend(8'h00, 32'h0a00_0002, 16'd80, 1'b0);
    connect(PROTO_UDP, 32'hffff_ffff, 16'hffff, 32'h0, 1'b0);
  endtask

  function automatic xlate_req_t random_req();
    xlate_req_t r;
    r.cmd       = CMD_W'($urandom);
    r.proto     = PROTO_W'($urandom);
    r.addr      = $urandom;
    r.port      = PORT_W'($urandom);
    r.rnd       = $urandom;
    r.sidx      = SIDX_W'($urandom);
    r.snum      = SNUM_W'($urandom);
    r.stot      = CNT_W'($urandom);
    r.bidx      = ID_W'($urandom);
    r.ena       = 1'($urandom);
    r.local_hit = 1'($urandom);
    return r;
  endfunction

  // Mostly connects to a few live services, with table churn and noise
  task automatic test_random_traffic();
    logic [ADDR_W-1:0] vip_addr [6];
    logic [PORT_W-1:0] vip_port [6];
    xlate_req_t        r;
    int unsigned       pick, k, cnt;
    for (int i = 0; i < 6; i++) begin
      vip_addr[i] = $urandom;
      vip_port[i] = PORT_W'($urandom);
    end
    // same address, different port
    vip_addr[5] = vip_addr[4];
    for (int b = 0; b < 32; b++) wr_backend(ID_W'(b), $urandom, PORT_W'($urandom), 1'b1);
    for (int i = 0; i < 6; i++) begin
      cnt = $urandom_range(1, 16);
      wr_service(SIDX_W'(i), vip_addr[i], vip_port[i], CNT_W'(cnt), 1'b1);
      for (int s = 1; s <= cnt; s++)
        wr_slot(SIDX_W'(i), SNUM_W'(s), ID_W'($urandom_range(31)), 1'b1);
    end

    for (int n = 0; n < 1700; n++) begin
      no_gaps = (n >= 500 && n < 800);
      if (n == 1200) wait_results_done();
      r    = random_req();
      pick = $urandom_range(99);
      k    = $urandom_range(5);
      if (pick < 45) begin
        r.cmd  = CMD_CONNECT;
        r.addr = vip_addr[k];
        r.port = vip_port[k];
        case ($urandom_range(4))
          0, 1, 2: r.proto = PROTO_TCP;
          3:       r.proto = PROTO_UDP;
          default: ;
        endcase
        r.local_hit = ($urandom_range(3) == 0);
      end else if (pick < 55) begin
        r.cmd = CMD_CONNECT;
      end else if (pick < 70) begin
        r.cmd  = CMD_WR_SLOT;
        r.sidx = SIDX_W'($urandom_range(7));
        if ($urandom_range(9) != 0) r.snum = SNUM_W'($urandom_range(1, 16));
        if ($urandom_range(9) != 0) r.bidx = ID_W'($urandom_range(31));
        r.ena = ($urandom_range(9) != 0);
      end else if (pick < 85) begin
        r.cmd = CMD_WR_BACKEND;
        if ($urandom_range(9) != 0) r.bidx = ID_W'($urandom_range(31));
        r.ena = ($urandom_range(6) != 0);
      end else if (pick < 95) begin
        r.cmd = CMD_WR_SVC;
        if ($urandom_range(4) != 0) begin
          r.addr = vip_addr[k];
          r.port = vip_port[k];
        end
        if ($urandom_range(9) != 0) r.stot = CNT_W'($urandom_range(1, 16));
        r.ena = ($urandom_range(6) != 0);
      end
      send_word(r);
    end
    no_gaps = 1'b0;
  endtask

  // Result check and output back-pressure
  always @(posedge clk) begin : check_results
    xlate_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      {got.id, got.port, got.addr} = m_axis_tdata;
      if (pending_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result word: status %0d addr %h port %h id %0d",
                   got.status, got.addr, got.port, got.id);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.addr != want.addr ||
            got.port != want.port || got.id != want.id) begin
          if (errors < 10)
            $display("mismatch: exp st %0d a %h p %h id %0d, got st %0d a %h p %h id %0d",
                     want.status, want.addr, want.port, want.id,
                     got.status, got.addr, got.port, got.id);
          errors++;
        end
      end
    end
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 25);
  end

  initial begin
    clear_tables();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_tables();
    test_translation();
    test_special_cases();
    test_random_traffic();
    wait_results_done();
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== service_backend_translator.f =====
design/sbt_pkg.sv
design/service_backend_translator.sv
test/service_backend_translator_tb.sv
